/* hw/rtl/tlp3d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tlp3d_pkg;

  // Field widths
  localparam int CW = 10;  // coarse coordinate
  localparam int FW = 11;  // fine coordinate and grid size
  localparam int VW = 32;  // Q16.16 value
  localparam int NR = 8;   // results per coarse point at most
  localparam int IW = 3;   // result index

  localparam int          MAX_COARSE_DEF = 1024;
  localparam logic [FW-1:0] NC_MIN       = 11'd2;

  // One coarse point after interpolation: all eight candidate values and
  // the mask of the ones that are emitted
  typedef struct packed {
    logic [CW-1:0]          cx;
    logic [CW-1:0]          cy;
    logic [CW-1:0]          cz;
    logic [NR-1:0]          mask;
    logic [NR-1:0][VW-1:0]  vals;
  } item_t;

endpackage

`default_nettype wire

/* hw/rtl/trilinear_prolongation_3d_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Each point passes stages 1 to 4, the serializer mask and the output registers.
// The serializer emits a point's results one after another (8 for an interior
// point) and takes the next point on the last one; an empty point still loads.
// The four-stage adder pipeline stalls only when the output serializer is full.
// Reset: nc returns to 2, all pipeline stages and results are emptied.
module trilinear_prolongation_3d_core
  import tlp3d_pkg::*;
#(
  parameter int MAX_COARSE = MAX_COARSE_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [CW-1:0]   cx,
  input  wire logic [CW-1:0]   cy,
  input  wire logic [CW-1:0]   cz,
  input  wire logic signed [VW-1:0] v000,
  input  wire logic signed [VW-1:0] v100,
  input  wire logic signed [VW-1:0] v010,
  input  wire logic signed [VW-1:0] v110,
  input  wire logic signed [VW-1:0] v001,
  input  wire logic signed [VW-1:0] v101,
  input  wire logic signed [VW-1:0] v011,
  input  wire logic signed [VW-1:0] v111,
  input  wire logic            wr_en,
  input  wire logic [FW-1:0]   wr_data,
  output logic                 result_valid,
  output logic [FW-1:0]        fx,
  output logic [FW-1:0]        fy,
  output logic [FW-1:0]        fz,
  output logic signed [VW-1:0] fine_value,
  output logic                 last
);

  localparam logic [16:0] MAX_C = 17'(MAX_COARSE);

  // Grid size register, clamped on write
  logic [FW-1:0] nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      nc <= NC_MIN;
    end else if (wr_en) begin
      if (wr_data < NC_MIN) nc <= NC_MIN;
      else if ({6'd0, wr_data} > MAX_C) nc <= MAX_C[FW-1:0];
      else nc <= wr_data;
    end
  end

  // Stage valids and ready chain
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ser_ready;

  assign rdy4 = !v4 || ser_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign busy = !rdy1;

  // Stage 1: input registers
  logic [CW-1:0] x1, y1, z1;
  logic signed [VW-1:0] a00_1, a10_1, a01_1, a11_1, b00_1, b10_1, b01_1, b11_1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (rdy1) v1 <= start;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1 <= cx; y1 <= cy; z1 <= cz;
      a00_1 <= v000; a10_1 <= v100; a01_1 <= v010; a11_1 <= v110;
      b00_1 <= v001; b10_1 <= v101; b01_1 <= v011; b11_1 <= v111;
    end
  end

  // Boundary flags, result mask and zeroed Dirichlet planes
  logic none, hx, hy, lowz, upz;
  logic [NR-1:0] mask1;
  logic [3:0] pat;
  logic signed [VW-1:0] za00, za10, za01, za11, zb00, zb10, zb01, zb11;

  always_comb begin
    none = ({1'b0, x1} >= nc) || ({1'b0, y1} >= nc) || ({1'b0, z1} >= nc) ||
           ({1'b0, z1} == nc - 11'd1);
    hx   = {1'b0, x1} < nc - 11'd1;
    hy   = {1'b0, y1} < nc - 11'd1;
    lowz = (z1 == '0);
    upz  = ({1'b0, z1} + 11'd2) == nc;
    pat  = {hx && hy, hy, hx, 1'b1};
    mask1 = {pat & {4{!(lowz && upz)}}, pat & {4{!lowz}}} & {NR{!none}};
    za00 = lowz ? '0 : a00_1;
    za10 = lowz ? '0 : a10_1;
    za01 = lowz ? '0 : a01_1;
    za11 = lowz ? '0 : a11_1;
    zb00 = upz ? '0 : b00_1;
    zb10 = upz ? '0 : b10_1;
    zb01 = upz ? '0 : b01_1;
    zb11 = upz ? '0 : b11_1;
  end

  // Stage 2: pair sums
  logic [CW-1:0] x2, y2, z2;
  logic [NR-1:0] mask2;
  logic signed [VW-1:0] a00_2;
  logic signed [VW:0] e0_2, e1_2, e2_2, c0_2, c1_2, c2_2, c3_2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (rdy2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      x2 <= x1; y2 <= y1; z2 <= z1;
      mask2 <= mask1;
      a00_2 <= za00;
      e0_2  <= {za00[VW-1], za00} + {za10[VW-1], za10};
      e1_2  <= {za01[VW-1], za01} + {za11[VW-1], za11};
      e2_2  <= {za00[VW-1], za00} + {za01[VW-1], za01};
      c0_2  <= {za00[VW-1], za00} + {zb00[VW-1], zb00};
      c1_2  <= {za10[VW-1], za10} + {zb10[VW-1], zb10};
      c2_2  <= {za01[VW-1], za01} + {zb01[VW-1], zb01};
      c3_2  <= {za11[VW-1], za11} + {zb11[VW-1], zb11};
    end
  end

  // Stage 3: quad sums
  logic [CW-1:0] x3, y3, z3;
  logic [NR-1:0] mask3;
  logic signed [VW-1:0] a00_3;
  logic signed [VW:0] e0_3, e2_3, c0_3;
  logic signed [VW+1:0] s3_3, s5_3, s6_3, q1_3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (rdy3) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      x3 <= x2; y3 <= y2; z3 <= z2;
      mask3 <= mask2;
      a00_3 <= a00_2;
      e0_3  <= e0_2;
      e2_3  <= e2_2;
      c0_3  <= c0_2;
      s3_3  <= {e0_2[VW], e0_2} + {e1_2[VW], e1_2};
      s5_3  <= {c0_2[VW], c0_2} + {c1_2[VW], c1_2};
      s6_3  <= {c0_2[VW], c0_2} + {c2_2[VW], c2_2};
      q1_3  <= {c2_2[VW], c2_2} + {c3_2[VW], c3_2};
    end
  end

  // Stage 4: full sum and floor shifts (bit selects of the exact sums)
  logic signed [VW+2:0] s7;
  item_t item4;

  assign s7 = {s5_3[VW+1], s5_3} + {q1_3[VW+1], q1_3};

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (rdy4) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      item4.cx      <= x3;
      item4.cy      <= y3;
      item4.cz      <= z3;
      item4.mask    <= mask3;
      item4.vals[0] <= a00_3;
      item4.vals[1] <= e0_3[VW:1];
      item4.vals[2] <= e2_3[VW:1];
      item4.vals[3] <= s3_3[VW+1:2];
      item4.vals[4] <= c0_3[VW:1];
      item4.vals[5] <= s5_3[VW+1:2];
      item4.vals[6] <= s6_3[VW+1:2];
      item4.vals[7] <= s7[VW+2:3];
    end
  end

  // Output serializer: one fine value per cycle while results are pending
  tlp3d_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .load         (v4 && ser_ready),
    .item         (item4),
    .ready        (ser_ready),
    .result_valid (result_valid),
    .fx           (fx),
    .fy           (fy),
    .fz           (fz),
    .fine_value   (fine_value),
    .last         (last)
  );

  // Results of one point go out on consecutive cycles
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("gap inside the results of one point");

  // A start transfer always lands in the first stage
  a_capture: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> v1)
    else $error("accepted point not captured");

  // A stalled last stage keeps its point
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !ser_ready |=> v4 && $stable(item4))
    else $error("stalled point lost or changed");

endmodule

`default_nettype wire

/* hw/rtl/tlp3d_serial.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlp3d_serial
  import tlp3d_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire item_t         item,
  output logic               ready,
  output logic               result_valid,
  output logic [FW-1:0]      fx,
  output logic [FW-1:0]      fy,
  output logic [FW-1:0]      fz,
  output logic signed [VW-1:0] fine_value,
  output logic               last
);

  logic [NR-1:0]         mask;
  logic [NR-1:0][VW-1:0] vals;
  logic [CW-1:0]         cx;
  logic [CW-1:0]         cy;
  logic [CW-1:0]         cz;
  logic [NR-1:0]         lowbit;
  logic [NR-1:0]         rest;
  logic [IW-1:0]         idx;

  // Pick the lowest pending result
  always_comb begin
    lowbit = mask & (~mask + 8'd1);
    rest   = mask & ~lowbit;
    idx    = '0;
    for (int i = 0; i < NR; i++) begin
      if (lowbit[i]) idx = IW'(i);
    end
  end

  // Free for the next point once the current one is on its final result or has none
  assign ready = (rest == '0);

  // Pending mask and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      mask         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= |mask;
      if (load) mask <= item.mask;
      else mask <= rest;
    end
  end

  // Held point and output registers
  always_ff @(posedge clk) begin
    if (load) begin
      vals <= item.vals;
      cx   <= item.cx;
      cy   <= item.cy;
      cz   <= item.cz;
    end
    fx         <= {cx, idx[0]};
    fy         <= {cy, idx[1]};
    fz         <= {cz, idx[2]};
    fine_value <= vals[idx];
    last       <= ready;
  end

endmodule

`default_nettype wire
